@@ rtl/fifc_pkg.sv @@
// shared types and format codes for the float/integer format converter
package fifc_pkg;

   typedef enum logic [2:0] {
      FMT_U1  = 3'd0,
      FMT_I1  = 3'd1,
      FMT_U16 = 3'd2,
      FMT_I16 = 3'd3,
      FMT_U32 = 3'd4,
      FMT_I32 = 3'd5,
      FMT_F32 = 3'd6,
      FMT_BAD = 3'd7
   } fmt_type;

   localparam logic [1:0] STATUS_CONVERTED   = 2'd0;
   localparam logic [1:0] STATUS_COPIED      = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   localparam logic [1:0] CSR_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] CSR_TARGET_FORMAT = 2'd1;

   localparam logic [7:0] EXP_BIAS = 8'd127;

   typedef struct packed {
      logic [31:0] element_in;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [31:0] element_out;
      logic [1:0]  status;
      logic        saturated;
      logic        last_out;
   } rsp_type;

endpackage

@@ rtl/float_integer_format_converter_core.sv @@
// float32 <-> integer element converter, one item per cycle
//
//   channel | ports                              | direction
//   req     | req_start, req_busy, req_data      | in (busy out)
//   rsp     | rsp_strobe, rsp_data               | out
//   csr     | csr_write, csr_index, csr_data     | in
//
// an item is taken when req_start is high and req_busy is low; busy is always low
// the result appears on rsp_data with rsp_strobe after the input register and then
// the result register; a new item may enter every cycle
// reset clears the valid flags and sets the formats to float32 -> i32
// the receiver cannot stall: each result is shown for exactly one cycle
module float_integer_format_converter_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   output logic                  req_busy,
   input  fifc_pkg::req_type     req_data,
   output logic                  rsp_strobe,
   output fifc_pkg::rsp_type     rsp_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [2:0]            csr_data
);

   // low bits of the bias, for the unbiased exponent in range 0..31
   localparam logic [4:0] EXP5 = 5'd31;

   fifc_pkg::fmt_type src_ff, tgt_ff;
   fifc_pkg::req_type req_ff;
   logic              req_vld_ff;
   fifc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_vld_ff;

   assign req_busy   = 1'b0;
   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff     <= fifc_pkg::FMT_F32;
         tgt_ff     <= fifc_pkg::FMT_I32;
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               fifc_pkg::CSR_SOURCE_FORMAT: src_ff <= fifc_pkg::fmt_type'(csr_data);
               fifc_pkg::CSR_TARGET_FORMAT: tgt_ff <= fifc_pkg::fmt_type'(csr_data);
               default: ;
            endcase
         end
         req_vld_ff <= req_start;
         rsp_vld_ff <= req_vld_ff;
      end
      req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   // float fields
   logic [31:0] x;
   logic        f_neg, f_nan, f_zero, f_big;
   logic [7:0]  f_exp;
   logic [23:0] f_man;
   logic [4:0]  f_e;
   logic [54:0] f_sh;
   logic [31:0] f_mag;
   logic [31:0] f2i_res;
   logic        f2i_sat;

   // integer to float
   logic        i_neg;
   logic [31:0] i_mag;
   logic [4:0]  i_p;
   logic [31:0] i_norm;
   logic [24:0] i_keep;
   logic        i_grd, i_stk;
   logic [7:0]  i_exp;
   logic [31:0] i2f_res;

   always_comb begin
      x      = req_ff.element_in;
      f_neg  = x[31];
      f_exp  = x[30:23];
      f_nan  = (f_exp == 8'hFF) && (x[22:0] != 23'd0);
      f_zero = (x[30:0] == 31'd0);
      f_man  = {1'b1, x[22:0]};
      f_big  = (f_exp >= 8'd159);
      f_e    = f_exp[4:0] - EXP5;
      f_sh   = {31'd0, f_man} << f_e;
      f_mag  = (f_exp < fifc_pkg::EXP_BIAS) ? 32'd0 : f_sh[54:23];
      f2i_res = 32'd0;
      f2i_sat = 1'b0;
      case (tgt_ff)
         fifc_pkg::FMT_U1: begin
            f2i_res = {31'd0, !f_zero};
            f2i_sat = f_nan;
         end
         fifc_pkg::FMT_I1: begin
            f2i_res = {31'd0, !f_nan && !f_neg && !f_zero};
            f2i_sat = f_nan;
         end
         fifc_pkg::FMT_U16: begin
            if (f_nan) f2i_sat = 1'b1;
            else if (f_neg) f2i_sat = (f_mag != 32'd0) || f_big;
            else if (f_big || f_mag[31:16] != 16'd0) begin
               f2i_sat = 1'b1; f2i_res = 32'h0000_FFFF;
            end else f2i_res = f_mag;
         end
         fifc_pkg::FMT_U32: begin
            if (f_nan) f2i_sat = 1'b1;
            else if (f_neg) f2i_sat = (f_mag != 32'd0) || f_big;
            else if (f_big) begin
               f2i_sat = 1'b1; f2i_res = 32'hFFFF_FFFF;
            end else f2i_res = f_mag;
         end
         fifc_pkg::FMT_I16: begin
            if (f_nan) f2i_sat = 1'b1;
            else if (f_neg) begin
               if (f_big || f_mag > 32'h0000_8000) begin
                  f2i_sat = 1'b1; f2i_res = 32'h0000_8000;
               end else f2i_res = {16'd0, 16'(32'd0 - f_mag)};
            end else if (f_big || f_mag > 32'h0000_7FFF) begin
               f2i_sat = 1'b1; f2i_res = 32'h0000_7FFF;
            end else f2i_res = f_mag;
         end
         fifc_pkg::FMT_I32: begin
            if (f_nan) f2i_sat = 1'b1;
            else if (f_neg) begin
               if (f_big || f_mag > 32'h8000_0000) begin
                  f2i_sat = 1'b1; f2i_res = 32'h8000_0000;
               end else f2i_res = 32'd0 - f_mag;
            end else if (f_big || f_mag > 32'h7FFF_FFFF) begin
               f2i_sat = 1'b1; f2i_res = 32'h7FFF_FFFF;
            end else f2i_res = f_mag;
         end
         default: ;
      endcase

      i_neg = 1'b0;
      i_mag = 32'd0;
      case (src_ff)
         fifc_pkg::FMT_U1:  i_mag = {31'd0, x[0]};
         fifc_pkg::FMT_I1: begin
            i_mag = 32'd1; i_neg = !x[0];
         end
         fifc_pkg::FMT_U16: i_mag = {16'd0, x[15:0]};
         fifc_pkg::FMT_I16: begin
            i_neg = x[15];
            i_mag = {16'd0, x[15] ? 16'(17'h10000 - {1'b0, x[15:0]}) : x[15:0]};
            if (x[15] && x[14:0] == 15'd0) i_mag = 32'h0000_8000;
         end
         fifc_pkg::FMT_U32: i_mag = x;
         default: begin
            i_neg = x[31];
            i_mag = x[31] ? 32'd0 - x : x;
         end
      endcase
      // leading one position
      i_p = 5'd0;
      for (int k = 0; k < 32; k++) begin
         if (i_mag[k]) i_p = 5'(k);
      end
      i_norm = i_mag << (5'd31 - i_p);
      i_grd  = i_norm[7];
      i_stk  = (i_norm[6:0] != 7'd0);
      i_keep = {1'b0, i_norm[31:8]} +
               25'(i_grd && (i_stk || i_norm[8]));
      i_exp  = fifc_pkg::EXP_BIAS + {3'd0, i_p} + {7'd0, i_keep[24]};
      if (i_mag == 32'd0) i2f_res = 32'd0;
      else i2f_res = {i_neg, i_exp,
                      i_keep[24] ? i_keep[23:1] : i_keep[22:0]};

      rsp_in.element_out = 32'd0;
      rsp_in.status      = fifc_pkg::STATUS_UNSUPPORTED;
      rsp_in.saturated   = 1'b0;
      rsp_in.last_out    = req_ff.last_in;
      if (src_ff == fifc_pkg::FMT_BAD || tgt_ff == fifc_pkg::FMT_BAD) begin
      end else if (src_ff == tgt_ff) begin
         rsp_in.status = fifc_pkg::STATUS_COPIED;
         if (src_ff == fifc_pkg::FMT_U1 || src_ff == fifc_pkg::FMT_I1)
            rsp_in.element_out = {31'd0, x[0]};
         else if (src_ff == fifc_pkg::FMT_U16 || src_ff == fifc_pkg::FMT_I16)
            rsp_in.element_out = {16'd0, x[15:0]};
         else
            rsp_in.element_out = x;
      end else if (src_ff == fifc_pkg::FMT_F32) begin
         rsp_in.status      = fifc_pkg::STATUS_CONVERTED;
         rsp_in.element_out = f2i_res;
         rsp_in.saturated   = f2i_sat;
      end else if (tgt_ff == fifc_pkg::FMT_F32) begin
         rsp_in.status      = fifc_pkg::STATUS_CONVERTED;
         rsp_in.element_out = i2f_res;
      end
   end

endmodule
